@@ rtl/core/bpdc_pkg.sv @@
// Package for the button press duration classifier: phase codes and shared types.
package bpdc_pkg;

   // Widths of the payload fields.
   localparam int TimeWidth  = 32;
   localparam int ThreshWidth = 16;
   localparam int PhaseWidth = 3;

   typedef logic [PhaseWidth-1:0]  phase_type;
   typedef logic [TimeWidth-1:0]   time_type;
   typedef logic [ThreshWidth-1:0] thresh_type;

   // Phase codes of one button.
   localparam phase_type PhIdle       = 3'd0;
   localparam phase_type PhActive     = 3'd1;
   localparam phase_type PhShortPress = 3'd2;
   localparam phase_type PhShortHold  = 3'd3;
   localparam phase_type PhLongPress  = 3'd4;
   localparam phase_type PhLongHold   = 3'd5;

   // Configuration register indexes.
   localparam logic RegShortPress = 1'b0;
   localparam logic RegLongPress  = 1'b1;

   // Hold thresholds handed to every button machine.
   typedef struct packed {
      thresh_type short_press_ms;
      thresh_type long_press_ms;
   } thresh_cfg_type;

endpackage

@@ rtl/core/bpdc_button.sv @@
// Phase machine and press start time for one button.
module bpdc_button
   import bpdc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           update,
   input  logic           pressed,
   input  time_type       now_ms,
   input  thresh_cfg_type thresh,
   output phase_type      phase
);

   logic [PhaseWidth-1:0] phase_ff;
   logic [PhaseWidth-1:0] phase_in;
   time_type              start_ff;
   time_type              start_in;
   time_type              held;
   logic                  short_reached;
   logic                  long_reached;

   // Held time wraps modulo 2^32, so a plain subtract gives it.
   assign held          = now_ms - start_ff;
   assign short_reached = held >= {{(TimeWidth-ThreshWidth){1'b0}}, thresh.short_press_ms};
   assign long_reached  = held >= {{(TimeWidth-ThreshWidth){1'b0}}, thresh.long_press_ms};

   // Next phase; a release returns to idle from any phase.
   always_comb begin
      phase_in = phase_ff;
      start_in = start_ff;
      case (phase_ff)
         PhIdle: begin
            if (pressed) begin
               phase_in = PhActive;
               start_in = now_ms;
            end
         end
         PhActive: begin
            if (!pressed) begin
               phase_in = PhIdle;
            end else if (short_reached) begin
               phase_in = PhShortPress;
            end
         end
         PhShortPress: begin
            phase_in = pressed ? PhShortHold : PhIdle;
         end
         PhShortHold: begin
            if (!pressed) begin
               phase_in = PhIdle;
            end else if (long_reached) begin
               phase_in = PhLongPress;
            end
         end
         PhLongPress: begin
            phase_in = pressed ? PhLongHold : PhIdle;
         end
         PhLongHold: begin
            phase_in = pressed ? PhLongHold : PhIdle;
         end
         default: begin
            phase_in = PhIdle;
         end
      endcase
   end

   // The phase register doubles as this button's result field.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhIdle;
      end else if (update) begin
         phase_ff <= phase_in;
      end
   end

   // Start time is captured when a press is first seen and clears on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
      end else if (update) begin
         start_ff <= start_in;
      end
   end

   assign phase = phase_ff;

endmodule

@@ rtl/core/button_press_duration_classifier.sv @@
// Top level of the button press duration classifier: handshake, registers and four phase machines.
//
//   channel | direction | handshake                   | payload
//   req     | in        | req_valid / req_stall       | now_ms, four active-low pin levels
//   rsp     | out       | rsp_valid / rsp_stall       | four 3-bit button phases
//   csr     | in/out    | APB psel/penable/pwrite     | short_press_ms at 0x0, long_press_ms at 0x4
//
// One transaction per clock unless rsp_stall holds the response: a request is
// captured in the input register, then the four phase machines update from it
// and their phase registers form the response.
// The response holds while rsp_stall is high; the input register then keeps
// its transaction and req_stall rises only when it is full and cannot move on.
// Synchronous reset sets every button idle and the thresholds to 50 and 1000 ms.
module button_press_duration_classifier
   import bpdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  time_type    req_now_ms,
   input  logic        req_pin_set,
   input  logic        req_pin_up,
   input  logic        req_pin_down,
   input  logic        req_pin_play,
   // Response channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output phase_type   rsp_set_phase,
   output phase_type   rsp_up_phase,
   output phase_type   rsp_down_phase,
   output phase_type   rsp_play_phase,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic           in_valid_ff;
   logic           in_valid_in;
   time_type       now_ff;
   logic [3:0]     pins_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   thresh_cfg_type thresh_ff;
   thresh_cfg_type thresh_in;
   logic           req_take;
   logic           advance;
   logic           csr_write;

   // Handshake control between the input register and the response.
   assign advance      = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall    = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register for the request payload.
   always_ff @(posedge clock) begin
      if (req_take) begin
         now_ff  <= req_now_ms;
         pins_ff <= {req_pin_play, req_pin_down, req_pin_up, req_pin_set};
      end
   end

   // Configuration registers.
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      thresh_in = thresh_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            RegShortPress: thresh_in.short_press_ms = csr_pwdata[ThreshWidth-1:0];
            RegLongPress:  thresh_in.long_press_ms  = csr_pwdata[ThreshWidth-1:0];
            default:       thresh_in = thresh_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.short_press_ms <= 16'd50;
         thresh_ff.long_press_ms  <= 16'd1000;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_paddr[2])
         RegShortPress: csr_prdata = {16'd0, thresh_ff.short_press_ms};
         RegLongPress:  csr_prdata = {16'd0, thresh_ff.long_press_ms};
         default:       csr_prdata = 32'd0;
      endcase
   end

   // One phase machine per button; pins are active low.
   bpdc_button u_set (
      .clock   (clock),
      .reset   (reset),
      .update  (advance),
      .pressed (!pins_ff[0]),
      .now_ms  (now_ff),
      .thresh  (thresh_ff),
      .phase   (rsp_set_phase)
   );

   bpdc_button u_up (
      .clock   (clock),
      .reset   (reset),
      .update  (advance),
      .pressed (!pins_ff[1]),
      .now_ms  (now_ff),
      .thresh  (thresh_ff),
      .phase   (rsp_up_phase)
   );

   bpdc_button u_down (
      .clock   (clock),
      .reset   (reset),
      .update  (advance),
      .pressed (!pins_ff[2]),
      .now_ms  (now_ff),
      .thresh  (thresh_ff),
      .phase   (rsp_down_phase)
   );

   bpdc_button u_play (
      .clock   (clock),
      .reset   (reset),
      .update  (advance),
      .pressed (!pins_ff[3]),
      .now_ms  (now_ff),
      .thresh  (thresh_ff),
      .phase   (rsp_play_phase)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ test/tb_button_press_duration_classifier.sv @@
// Testbench for the button press duration classifier: directed and random ticks checked against a phase predictor.
import bpdc_pkg::*;

// Predicts the four button phases for each accepted tick and checks them against the responses.
class phase_scoreboard;
   typedef logic [3:0][PhaseWidth-1:0] phase_quad;

   thresh_type short_ms;
   thresh_type long_ms;
   phase_type  phase [4];
   time_type   press_start [4];
   phase_quad  expected_q [$];
   int         errors;
   string      lane_name [4] = '{"set", "up", "down", "play"};

   // Return to the state right after reset.
   function void clear();
      short_ms = 16'd50;
      long_ms  = 16'd1000;
      for (int k = 0; k < 4; k++) begin
         phase[k]       = PhIdle;
         press_start[k] = '0;
      end
      expected_q.delete();
      errors = 0;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   // Advance every button by one tick. Levels are active low: bit 0 set, 1 up, 2 down, 3 play.
   function void note_tick(time_type now, logic [3:0] levels);
      phase_quad quad;
      time_type  held;
      bit        pressed;
      for (int k = 0; k < 4; k++) begin
         pressed = !levels[k];
         held    = now - press_start[k];
         case (phase[k])
            PhIdle: begin
               if (pressed) begin
                  press_start[k] = now;
                  phase[k]       = PhActive;
               end
            end
            PhActive: begin
               if (!pressed) phase[k] = PhIdle;
               else if (held >= 32'(short_ms)) phase[k] = PhShortPress;
            end
            PhShortPress: phase[k] = pressed ? PhShortHold : PhIdle;
            PhShortHold: begin
               if (!pressed) phase[k] = PhIdle;
               else if (held >= 32'(long_ms)) phase[k] = PhLongPress;
            end
            PhLongPress: phase[k] = pressed ? PhLongHold : PhIdle;
            PhLongHold: begin
               if (!pressed) phase[k] = PhIdle;
            end
            default: phase[k] = PhIdle;
         endcase
         quad[k] = phase[k];
      end
      expected_q.push_back(quad);
   endfunction

   // Compare one response with the oldest prediction, field by field.
   function void check_phases(phase_quad got);
      phase_quad want;
      if (expected_q.size() == 0) begin
         $display("%0t: response %h arrived, expected no transaction", $time, got);
         errors++;
         return;
      end
      want = expected_q.pop_front();
      for (int k = 0; k < 4; k++) begin
         if (got[k] !== want[k]) begin
            $display("%0t: %s phase expected %0d, got %0d", $time, lane_name[k], want[k], got[k]);
            errors++;
         end
      end
   endfunction
endclass

module tb_button_press_duration_classifier;
   import bpdc_pkg::*;

   localparam int       QuietLimit = 2000;
   localparam time_type WrapBase   = 32'hFFFF_FFF0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   time_type    req_now_ms = '0;
   logic        req_pin_set = 1'b1;
   logic        req_pin_up = 1'b1;
   logic        req_pin_down = 1'b1;
   logic        req_pin_play = 1'b1;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   phase_type   rsp_set_phase;
   phase_type   rsp_up_phase;
   phase_type   rsp_down_phase;
   phase_type   rsp_play_phase;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int sender_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;
   phase_scoreboard tracker;

   always #2 clock = ~clock;

   button_press_duration_classifier dut (.*);

   // The receiver stalls at random at the falling edge.
   always @(negedge clock) begin
      rsp_stall = (recv_stall_pct != 0) && ($urandom_range(1, 100) <= recv_stall_pct);
   end

   // Check every accepted response.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_phases({rsp_play_phase, rsp_down_phase, rsp_up_phase, rsp_set_phase});
   end

   // Watchdog: end the run when no transaction moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Offer one tick, with random gaps before it, and wait until it is accepted.
   task automatic send_tick(time_type now, logic [3:0] levels);
      @(negedge clock);
      while (sender_idle_pct != 0 && $urandom_range(1, 100) <= sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid    = 1'b1;
      req_now_ms   = now;
      req_pin_set  = levels[0];
      req_pin_up   = levels[1];
      req_pin_down = levels[2];
      req_pin_play = levels[3];
      do @(posedge clock); while (req_stall);
      tracker.note_tick(now, levels);
   endtask

   // Stop sending and wait until every predicted response has arrived.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write one threshold with junk in the upper bits, then read it back.
   task automatic write_threshold(logic index, thresh_type value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = {index, 2'b00};
      csr_pwdata  = {16'($urandom), value};
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (index == RegShortPress) tracker.short_ms = value;
      else tracker.long_ms = value;
      @(negedge clock);
      csr_pwrite  = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (csr_prdata !== 32'(value)) begin
         $display("%0t: register %0d read expected %h, got %h", $time, index, 32'(value),
                  csr_prdata);
         tracker.errors++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // Advance time and the buttons: mostly held presses with random releases, sometimes noise.
   task automatic random_tick(inout time_type now, inout logic [3:0] levels);
      int span;
      span = ((tracker.short_ms > tracker.long_ms) ? tracker.short_ms : tracker.long_ms) / 3 + 1;
      if ($urandom_range(0, 19) == 0) now = $urandom;
      else now = now + time_type'($urandom_range(0, span));
      if ($urandom_range(0, 9) == 0) begin
         levels = 4'($urandom);
      end else begin
         for (int k = 0; k < 4; k++) begin
            if (!levels[k]) begin
               if ($urandom_range(0, 9) == 0) levels[k] = 1'b1;
            end else if ($urandom_range(0, 2) == 0) begin
               levels[k] = 1'b0;
            end
         end
      end
      send_tick(now, levels);
   endtask

   initial begin
      time_type   now;
      logic [3:0] levels;
      thresh_type short_pick;
      thresh_type long_pick;

      tracker = new();
      tracker.clear();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      sender_idle_pct = 26;
      recv_stall_pct  = 86;

      // Reset thresholds: every phase, both release paths and the time wrap.
      send_tick(32'd0, 4'b1111);
      send_tick(WrapBase, 4'b0000);
      send_tick(WrapBase + 32'd49, 4'b0000);
      send_tick(WrapBase + 32'd50, 4'b0001);
      send_tick(WrapBase + 32'd51, 4'b0010);
      send_tick(WrapBase + 32'd1000, 4'b0000);
      send_tick(WrapBase + 32'd1001, 4'b1000);
      send_tick(32'hFFFF_FFFF, 4'b0000);
      send_tick(32'hFFFF_FFFF, 4'b0000);
      send_tick(32'hFFFF_FFFF, 4'b1111);
      drain();

      // Zero thresholds: a press advances one phase per tick at a standing time.
      write_threshold(RegShortPress, 16'd0);
      write_threshold(RegLongPress, 16'd0);
      repeat (5) send_tick(32'd5, 4'b0000);
      send_tick(32'd5, 4'b0101);
      drain();

      // Largest thresholds: the short threshold just missed, then reached exactly.
      write_threshold(RegShortPress, 16'hFFFF);
      write_threshold(RegLongPress, 16'hFFFF);
      send_tick(32'd0, 4'b0000);
      send_tick(32'd65534, 4'b0000);
      send_tick(32'd65535, 4'b0000);
      send_tick(32'd65535, 4'b0000);
      send_tick(32'd131069, 4'b0000);
      send_tick(32'd131070, 4'b0000);
      send_tick(32'd131071, 4'b1010);
      drain();

      // Random ticks over several threshold settings and idling modes.
      for (int s = 0; s < 6; s++) begin
         case (s / 2)
            0: begin
               sender_idle_pct = 26;
               recv_stall_pct  = 86;
            end
            1: begin
               sender_idle_pct = 86;
               recv_stall_pct  = 26;
            end
            default: begin
               sender_idle_pct = 0;
               recv_stall_pct  = 0;
            end
         endcase
         case (s)
            0: begin short_pick = 16'd3;     long_pick = 16'd20;    end
            1: begin short_pick = 16'd0;     long_pick = 16'd0;     end
            2: begin short_pick = 16'hFFFF;  long_pick = 16'hFFFF;  end
            3: begin short_pick = 16'd500;   long_pick = 16'd10;    end
            4: begin short_pick = 16'd50;    long_pick = 16'd1000;  end
            default: begin
               short_pick = 16'($urandom_range(0, 300));
               long_pick  = 16'($urandom_range(0, 3000));
            end
         endcase
         write_threshold(RegShortPress, short_pick);
         write_threshold(RegLongPress, long_pick);
         now    = $urandom;
         levels = 4'b1111;
         for (int n = 0; n < 115; n++) begin
            random_tick(now, levels);
            // Hold off once mid-phase until the block has caught up.
            if (n == 57) drain();
         end
         drain();
      end

      if (tracker.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
